// ===== hdl/lfsp_pkg.sv =====
// Package for the lidar frame sync parser: header bytes, payload offsets,
// output field widths and the frame info struct shared by the modules.
// No dependencies.
package lfsp_pkg;

  // Default payload size and the fixed point count of one frame
  localparam int PAYLOAD_BYTES_DEF = 31;
  localparam int POINTS_PER_FRAME  = 8;
  localparam int PT_W              = $clog2(POINTS_PER_FRAME);

  // Header sequence 55 AA 03 08
  localparam logic [7:0] SYNC_B0 = 8'h55;
  localparam logic [7:0] SYNC_B1 = 8'hAA;
  localparam logic [7:0] SYNC_B2 = 8'h03;
  localparam logic [7:0] SYNC_B3 = 8'h08;

  // Payload byte offsets
  localparam int OFF_SPEED  = 0;
  localparam int OFF_START  = 2;
  localparam int OFF_POINT0 = 4;
  localparam int OFF_END    = 28;
  localparam int POINT_STEP = 3;

  // Angles are reported as raw word minus this bias (1/64 degree units)
  localparam logic [16:0] ANGLE_BIAS = 17'd40960;

  // Output tdata packing
  localparam int OUT_BITS   = PT_W + 16 + 8 + 17 + 17 + 16;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Per-frame words captured while the payload streams in
  typedef struct packed {
    logic [15:0]        speed;
    logic signed [16:0] ang_start;
    logic signed [16:0] ang_end;
  } frame_t;

  // Expected header byte for a given match position
  function automatic logic [7:0] sync_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = SYNC_B0;
      2'd1:    b = SYNC_B1;
      2'd2:    b = SYNC_B2;
      default: b = SYNC_B3;
    endcase
    return b;
  endfunction

  // Raw angle word to biased signed angle, modulo 2^17
  function automatic logic signed [16:0] angle_of(input logic [15:0] raw);
    return $signed({1'b0, raw} - ANGLE_BIAS);
  endfunction

endpackage

// ===== hdl/lfsp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/lfsp_hunt.sv =====
// Header hunter and payload writer: finds 55 AA 03 08, writes payload bytes
// to the store and captures speed and angle words. Depends on lfsp_pkg.
module lfsp_hunt #(
  parameter int PAYLOAD_BYTES = lfsp_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             byte_acc,
  input  logic [7:0]                       data_byte,
  output logic                             wr_en,
  output logic [$clog2(PAYLOAD_BYTES)-1:0] wr_addr,
  output logic                             frame_done,
  output lfsp_pkg::frame_t                 frame
);
  import lfsp_pkg::*;

  localparam int CNT_W = $clog2(PAYLOAD_BYTES);

  logic             in_payload_r, in_payload_nxt;
  logic [1:0]       match_r, match_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      speed_r, start_raw_r, end_raw_r;
  logic             last_byte;

  assign last_byte  = (cnt_r == CNT_W'(PAYLOAD_BYTES - 1));
  assign wr_en      = byte_acc && in_payload_r;
  assign wr_addr    = cnt_r;
  assign frame_done = wr_en && last_byte;

  // Hunt / payload counting
  always_comb begin
    in_payload_nxt = in_payload_r;
    match_nxt      = match_r;
    cnt_nxt        = cnt_r;
    if (byte_acc) begin
      if (!in_payload_r) begin
        if (data_byte == sync_byte(match_r)) begin
          match_nxt = match_r + 2'd1;
          if (match_r == 2'd3) begin
            in_payload_nxt = 1'b1;
          end
        end else begin
          // mismatching byte is not retried as a header start
          match_nxt = 2'd0;
        end
      end else if (last_byte) begin
        cnt_nxt        = '0;
        in_payload_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      match_r      <= 2'd0;
      cnt_r        <= '0;
    end else begin
      in_payload_r <= in_payload_nxt;
      match_r      <= match_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  // Capture the frame-wide words as they pass
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (cnt_r == CNT_W'(OFF_SPEED))     speed_r[7:0]      <= data_byte;
      if (cnt_r == CNT_W'(OFF_SPEED + 1)) speed_r[15:8]     <= data_byte;
      if (cnt_r == CNT_W'(OFF_START))     start_raw_r[7:0]  <= data_byte;
      if (cnt_r == CNT_W'(OFF_START + 1)) start_raw_r[15:8] <= data_byte;
      if (cnt_r == CNT_W'(OFF_END))       end_raw_r[7:0]    <= data_byte;
      if (cnt_r == CNT_W'(OFF_END + 1))   end_raw_r[15:8]   <= data_byte;
    end
  end

  assign frame.speed     = speed_r;
  assign frame.ang_start = angle_of(start_raw_r);
  assign frame.ang_end   = angle_of(end_raw_r);

endmodule

// ===== hdl/lfsp_emit.sv =====
// Point emitter: a small sequencer walks the payload store one byte per read,
// assembles each point and holds it in the output register. Depends on lfsp_pkg.
module lfsp_emit #(
  parameter int PAYLOAD_BYTES = lfsp_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             frame_done,
  input  lfsp_pkg::frame_t                 frame,
  output logic                             rd_en,
  output logic [$clog2(PAYLOAD_BYTES)-1:0] rd_addr,
  input  logic [7:0]                       rd_data,
  output logic                             busy,
  output logic                             pt_valid,
  input  logic                             pt_ready,
  output logic [lfsp_pkg::OUT_DATA_W-1:0]  pt_data,
  output logic                             pt_last
);
  import lfsp_pkg::*;

  localparam int AW = $clog2(PAYLOAD_BYTES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_CAP  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [1:0]      sel_r, sel_nxt;
  logic [PT_W-1:0] pt_r, pt_nxt;
  logic [7:0]      dist_lo_r, dist_hi_r, qual_r;
  logic            pt_done;

  assign pt_done = (pt_r == PT_W'(POINTS_PER_FRAME - 1));

  // Sequencer: one shared address incrementer steps through the store
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    sel_nxt   = sel_r;
    pt_nxt    = pt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (frame_done) begin
          state_nxt = ST_RD;
          addr_nxt  = AW'(OFF_POINT0);
          sel_nxt   = 2'd0;
          pt_nxt    = '0;
        end
      end
      ST_RD: begin
        state_nxt = ST_CAP;
      end
      ST_CAP: begin
        addr_nxt = addr_r + AW'(1);
        if (sel_r == 2'd2) begin
          sel_nxt   = 2'd0;
          state_nxt = ST_OUT;
        end else begin
          sel_nxt   = sel_r + 2'd1;
          state_nxt = ST_RD;
        end
      end
      ST_OUT: begin
        if (pt_ready) begin
          if (pt_done) begin
            state_nxt = ST_IDLE;
          end else begin
            pt_nxt    = pt_r + PT_W'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      addr_r  <= '0;
      sel_r   <= 2'd0;
      pt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      sel_r   <= sel_nxt;
      pt_r    <= pt_nxt;
    end
  end

  // Byte capture into the point register
  always_ff @(posedge clk) begin
    if (state_r == ST_CAP) begin
      case (sel_r)
        2'd0:    dist_lo_r <= rd_data;
        2'd1:    dist_hi_r <= rd_data;
        default: qual_r    <= rd_data;
      endcase
    end
  end

  assign rd_en    = (state_r == ST_RD);
  assign rd_addr  = addr_r;
  assign busy     = (state_r != ST_IDLE);
  assign pt_valid = (state_r == ST_OUT);
  assign pt_last  = pt_done;
  assign pt_data  = OUT_DATA_W'({frame.speed, frame.ang_end, frame.ang_start,
                                 qual_r, dist_hi_r, dist_lo_r, pt_r});

endmodule

// ===== hdl/lidar_frame_sync_parser_core.sv =====
// Readout: after the frame's last payload byte the emitter leaves idle and, for each
// point, does 3 store reads (each an ST_RD then an ST_CAP state) and then waits in
// ST_OUT until out_tready takes the point.
// Throughput: one byte per cycle while hunting or in payload; in_tready is low
// while the eight points of a frame are read out. Set by the single store read port.
// Reset: rst_n synchronous, active low; clears hunt, counters and sequencer.
module lidar_frame_sync_parser_core #(
  parameter int PAYLOAD_BYTES = lfsp_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] data_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [2:0] point_number, [18:3] distance, [26:19] quality, [43:27] ang_start,
  // [60:44] ang_end, [76:61] rotation_speed, rest zero
  output logic [lfsp_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast   // last_point
);
  import lfsp_pkg::*;

  localparam int AW = $clog2(PAYLOAD_BYTES);

  logic          byte_acc, wr_en, rd_en, frame_done, busy;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    rd_data;
  frame_t        frame;

  assign in_tready = !busy;
  assign byte_acc  = in_tvalid && in_tready;

  lfsp_hunt #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_hunt (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_acc   (byte_acc),
    .data_byte  (in_tdata),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .frame_done (frame_done),
    .frame      (frame)
  );

  lfsp_ram #(.WIDTH(8), .DEPTH(PAYLOAD_BYTES)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lfsp_emit #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_done (frame_done),
    .frame      (frame),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .busy       (busy),
    .pt_valid   (out_tvalid),
    .pt_ready   (out_tready),
    .pt_data    (out_tdata),
    .pt_last    (out_tlast)
  );

`ifndef ASSERT_OFF
  // No byte is taken while points are pending
  a_no_input_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input accepted while a point is pending");

  // A completed frame stops input on the next cycle
  a_frame_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> !in_tready)
    else $error("input still open after frame end");

  // Delivering the last point frees the input side
  a_last_releases: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("input not released after last point");

  // The store is never read and written in the same cycle
  a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("store read and write collide");
`endif

endmodule

// ===== dv/lfsp_checker.sv =====
// Scoreboard for the lidar frame sync parser: follows the byte stream on the
// input channel, predicts the eight point items of each frame and checks them
// on the output channel. Depends on lfsp_pkg.
`timescale 1ns / 1ps
module lfsp_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] data_byte
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [lfsp_pkg::OUT_DATA_W-1:0] out_tdata,  // point fields, see point_t
  input  logic                            out_tlast,  // last_point
  output int                              errors,
  output int                              waiting
);
  import lfsp_pkg::*;

  localparam int PAD_W    = OUT_DATA_W - OUT_BITS;
  localparam int LAST_POS = PAYLOAD_BYTES_DEF - 1;

  // One point item laid out as {tlast, tdata}
  typedef struct packed {
    logic               last;
    logic [PAD_W-1:0]   pad;
    logic [15:0]        speed;
    logic signed [16:0] ang_end;
    logic signed [16:0] ang_start;
    logic [7:0]         quality;
    logic [15:0]        distance;
    logic [PT_W-1:0]    point_no;
  } point_t;

  // Parser state mirrored from the byte stream
  logic       in_frame;
  logic [1:0] hdr_pos;
  logic [4:0] byte_pos;
  logic [7:0] frame_bytes [PAYLOAD_BYTES_DEF];

  point_t expected_points [$];
  int     mismatches;

  function automatic logic [15:0] word_at(input int lo);
    return {frame_bytes[lo + 1], frame_bytes[lo]};
  endfunction

  // Raw angle minus the bias, wrapped to 17 bits
  function automatic logic signed [16:0] biased_angle(input logic [15:0] raw);
    logic [16:0] diff;
    diff = {1'b0, raw} - ANGLE_BIAS;
    return $signed(diff);
  endfunction

  // Advance the parser by one byte; a completed frame queues its points
  task automatic parse_lidar_byte(input logic [7:0] b);
    logic [7:0] want_hdr;
    point_t     p;
    int         base;
    if (!in_frame) begin
      case (hdr_pos)
        2'd0:    want_hdr = SYNC_B0;
        2'd1:    want_hdr = SYNC_B1;
        2'd2:    want_hdr = SYNC_B2;
        default: want_hdr = SYNC_B3;
      endcase
      // a mismatching byte is not retried as a first header byte
      if (b == want_hdr) begin
        hdr_pos = hdr_pos + 2'd1;
        if (hdr_pos == 2'd0) in_frame = 1'b1;
      end else begin
        hdr_pos = 2'd0;
      end
    end else begin
      frame_bytes[byte_pos] = b;
      if (byte_pos == LAST_POS) begin
        byte_pos = '0;
        in_frame = 1'b0;
        for (int k = 0; k < POINTS_PER_FRAME; k++) begin
          base        = OFF_POINT0 + POINT_STEP * k;
          p           = '0;
          p.point_no  = PT_W'(k);
          p.distance  = word_at(base);
          p.quality   = frame_bytes[base + 2];
          p.ang_start = biased_angle(word_at(OFF_START));
          p.ang_end   = biased_angle(word_at(OFF_END));
          p.speed     = word_at(OFF_SPEED);
          p.last      = (k == POINTS_PER_FRAME - 1);
          expected_points.push_back(p);
        end
      end else begin
        byte_pos = byte_pos + 5'd1;
      end
    end
  endtask

  // Predict on accepted bytes, compare on accepted points
  always @(posedge clk) begin
    point_t got;
    point_t want;
    if (!rst_n) begin
      in_frame   = 1'b0;
      hdr_pos    = '0;
      byte_pos   = '0;
      mismatches = 0;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
      expected_points.delete();
    end else begin
      if (in_tvalid && in_tready) parse_lidar_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        got = point_t'({out_tlast, out_tdata});
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected point pt=%0d dist=%h q=%h start=%0d end=%0d",
                     $realtime, got.point_no, got.distance, got.quality, got.ang_start,
                     got.ang_end);
        end else begin
          want = expected_points.pop_front();
          if (got.point_no !== want.point_no || got.distance !== want.distance ||
              got.quality !== want.quality || got.ang_start !== want.ang_start ||
              got.ang_end !== want.ang_end || got.speed !== want.speed ||
              got.last !== want.last || got.pad !== want.pad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: point mismatch", $realtime);
              $display("  exp pt=%0d dist=%h q=%h start=%0d end=%0d speed=%h last=%b pad=%b",
                       want.point_no, want.distance, want.quality, want.ang_start,
                       want.ang_end, want.speed, want.last, want.pad);
              $display("  got pt=%0d dist=%h q=%h start=%0d end=%0d speed=%h last=%b pad=%b",
                       got.point_no, got.distance, got.quality, got.ang_start,
                       got.ang_end, got.speed, got.last, got.pad);
            end
          end
        end
      end
    end
    errors  <= mismatches;
    waiting <= expected_points.size();
  end

endmodule

// ===== dv/lidar_frame_sync_parser_core_tb.sv =====
// Top of the lidar frame sync parser bench: clock, reset, byte stimulus and
// output backpressure; checking is done by lfsp_checker.
// Depends on lfsp_pkg, lfsp_checker and lidar_frame_sync_parser_core.
`timescale 1ns / 1ps
module lidar_frame_sync_parser_core_tb;
  import lfsp_pkg::*;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [7:0]            in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  int errors;
  int waiting;
  int sent = 0;
  bit calm = 1'b0;

  lidar_frame_sync_parser_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  lfsp_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .errors    (errors),
    .waiting   (waiting)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Output backpressure, off during the calm stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 7);
    end
  end

  // Random byte, biased toward header values
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 4) == 0) return sync_byte(2'($urandom_range(0, 3)));
    return 8'($urandom);
  endfunction

  // Drive one byte and wait until it is taken
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    calm = (sent >= 200 && sent < 300);
  endtask

  // Header followed by a full payload
  task automatic send_frame(input logic [7:0] pl [PAYLOAD_BYTES_DEF]);
    for (int i = 0; i < 4; i++) send_byte(sync_byte(2'(i)));
    for (int i = 0; i < PAYLOAD_BYTES_DEF; i++) send_byte(pl[i]);
  endtask

  // Stimulus
  initial begin
    logic [7:0] pl [PAYLOAD_BYTES_DEF];
    logic [7:0] hi;
    logic [7:0] b;
    int         r;
    int         cut;
    int         n;
    int         rand_start;
    int         guard;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // repeated first header byte: 55 55 AA 03 08 must not lock
    send_byte(SYNC_B0);
    send_byte(SYNC_B0);
    send_byte(SYNC_B1);
    send_byte(SYNC_B2);
    send_byte(SYNC_B3);
    // header broken at its last byte
    send_byte(SYNC_B0);
    send_byte(SYNC_B1);
    send_byte(SYNC_B2);
    send_byte(8'h07);

    // extreme words: speed, angles, distances and qualities at both ends
    for (int f = 0; f < 2; f++) begin
      hi    = f ? 8'h00 : 8'hFF;
      pl[0] = hi;
      pl[1] = hi;
      pl[2] = ~hi;
      pl[3] = ~hi;
      for (int k = 0; k < POINTS_PER_FRAME; k++) begin
        pl[OFF_POINT0 + POINT_STEP * k]     = (k % 2) ? hi : ~hi;
        pl[OFF_POINT0 + POINT_STEP * k + 1] = (k % 2) ? hi : ~hi;
        pl[OFF_POINT0 + POINT_STEP * k + 2] = (k % 2) ? ~hi : hi;
      end
      pl[OFF_END]     = hi;
      pl[OFF_END + 1] = hi;
      pl[30]          = sync_byte(f ? 2'd3 : 2'd0);
      send_frame(pl);
    end

    // payload made only of header bytes is still payload
    for (int i = 0; i < PAYLOAD_BYTES_DEF; i++) pl[i] = sync_byte(2'(i % 4));
    send_frame(pl);

    // hold off until every point so far has come out
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);

    // random mix: mostly frames, some broken headers and noise
    rand_start = sent;
    while (sent - rand_start < 345) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        for (int i = 0; i < PAYLOAD_BYTES_DEF; i++) pl[i] = pick_byte();
        send_frame(pl);
      end else if (r < 88) begin
        cut = $urandom_range(1, 3);
        for (int i = 0; i < cut; i++) send_byte(sync_byte(2'(i)));
        do b = pick_byte(); while (b == sync_byte(2'(cut)));
        send_byte(b);
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) send_byte(pick_byte());
      end
    end

    // drain
    in_tvalid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (waiting != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);

    if (errors == 0 && waiting == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
